/* rtl/core/tqcp_pkg.sv */
// ----------------------------------------------------------------------------
// tqcp_pkg
// Shared types and constants of the two-queue cache directory.
// ----------------------------------------------------------------------------
package tqcp_pkg;

  localparam int KeyW    = 64;
  localparam int BytesW  = 20;
  localparam int LifeW   = 16;
  localparam int SecW    = 32;
  localparam int QbW     = 27;
  localparam int CntW    = 32;
  localparam int SlotW   = 6;
  localparam int StatW   = 3;
  localparam int CmdW    = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 32;
  localparam int StampW  = 64;

  localparam logic [CfgW-1:0] MaxBytesRst = 32'd8388608;
  localparam logic [CfgW-1:0] MinQ1Rst    = 32'd4194304;

  typedef enum logic [CmdW-1:0] {
    CmdGet    = 2'd0,
    CmdPut    = 2'd1,
    CmdRemove = 2'd2,
    CmdTick   = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StsHit      = 3'd0,
    StsMiss     = 3'd1,
    StsOk       = 3'd2,
    StsNotFound = 3'd3,
    StsEvicted  = 3'd4,
    StsTickDone = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxBytes   = 2'd0,
    CfgMinQ1Bytes = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StFind,
    StAct,
    StAlloc,
    StTail,
    StTailEv,
    StExp,
    StSize,
    StERd,
    StELd,
    StEFin
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [BytesW-1:0] bytes;
    logic [SecW-1:0]   expiry;
    logic [StampW-1:0] stamp;
  } slot_word_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [SlotW-1:0] slot;
  } rep_word_t;

endpackage

/* rtl/core/tqcp_ram.sv */
// ----------------------------------------------------------------------------
// tqcp_ram
// Generic RAM, one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tqcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/two_queue_cache_policy.sv */
// ----------------------------------------------------------------------------
// two_queue_cache_policy
// 2Q cache directory: slot table in RAM, recency kept as push stamps.
// Steps: key search, a tail scan per eviction, an expiry scan for ticks; evicted
// keys leave one result each, then one final result.
// One item at a time; the slot RAM read port is scanned one entry a cycle.
// Reset clears valid bits, byte totals, counters, clock and control state; no sweep.
// ----------------------------------------------------------------------------
module two_queue_cache_policy #(
  parameter int ENTRIES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tqcp_pkg::CmdW-1:0]     command_i,
  input  logic [tqcp_pkg::KeyW-1:0]     key_hash_i,
  input  logic [tqcp_pkg::BytesW-1:0]   entry_bytes_i,
  input  logic [tqcp_pkg::LifeW-1:0]    lifetime_sec_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tqcp_pkg::StatW-1:0]    status_o,
  output logic [tqcp_pkg::KeyW-1:0]     out_key_o,
  output logic [tqcp_pkg::SlotW-1:0]    out_slot_o,
  output logic [tqcp_pkg::QbW-1:0]      q1_total_o,
  output logic [tqcp_pkg::QbW-1:0]      q2_total_o,
  output logic [tqcp_pkg::CntW-1:0]     hits_o,
  output logic [tqcp_pkg::CntW-1:0]     misses_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tqcp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tqcp_pkg::CfgW-1:0]     cfg_data_i
);

  import tqcp_pkg::*;

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [SW-1:0] LastIdx = SW'(ENTRIES - 1);
  localparam logic [CW-1:0] EntCnt  = CW'(ENTRIES);

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [BytesW-1:0]  bytes_q, bytes_d;
  logic [LifeW-1:0]   life_q, life_d;
  logic [CfgW-1:0]    max_q, max_d, min_q, min_d;
  logic [ENTRIES-1:0] valid_q, valid_d, inq2_q, inq2_d;
  logic [QbW-1:0]     q1b_q, q1b_d, q2b_q, q2b_d;
  logic [CntW-1:0]    hits_q, hits_d, miss_q, miss_d;
  logic [SecW-1:0]    now_q, now_d;
  logic [StampW-1:0]  stamp_q, stamp_d;
  logic [CW-1:0]      scan_idx_q, scan_idx_d, rcnt_q, rcnt_d, e_q, e_d;
  logic               pend_q, pend_d;
  logic [SW-1:0]      pidx_q, pidx_d;
  logic               found_q, found_d;
  logic [SW-1:0]      fslot_q, fslot_d;
  logic [BytesW-1:0]  fbytes_q, fbytes_d;
  logic [SecW-1:0]    fexp_q, fexp_d;
  logic               tq_q, tq_d, talloc_q, talloc_d, tfound_q, tfound_d;
  logic [SW-1:0]      tslot_q, tslot_d;
  logic [KeyW-1:0]    tkey_q, tkey_d;
  logic [BytesW-1:0]  tbytes_q, tbytes_d;
  logic [StampW-1:0]  tbest_q, tbest_d;
  logic [BytesW-1:0]  extra_q, extra_d;
  logic               ph_q, ph_d;
  status_e            fin_sts_q, fin_sts_d;
  logic [SW-1:0]      fin_slot_q, fin_slot_d;

  logic               out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [StatW-1:0]   out_sts_q, out_sts_d;
  logic [KeyW-1:0]    out_key_q, out_key_d;
  logic [SlotW-1:0]   out_slot_q, out_slot_d;
  logic [QbW-1:0]     out_q1_q, out_q1_d, out_q2_q, out_q2_d;
  logic [CntW-1:0]    out_hits_q, out_hits_d, out_miss_q, out_miss_d;

  logic        slot_we, rep_we;
  logic [SW-1:0] slot_waddr;
  slot_word_t  slot_wdata, slot_rd;
  rep_word_t   rep_wdata, rep_rd;

  logic accept, scan_done, out_free, rd_valid, rd_q2, rd_expired, fexpired;
  logic q1ne, q2ne, over_max, cond1, q1_over_min, free_any, alloc_tq, bytes_over;
  logic [QbW+1:0]  tot;
  logic [QbW:0]    q1x;
  logic [SecW:0]   exp_sum;
  logic [SecW-1:0] exp_new, now_inc;
  logic [SW-1:0]   free_slot;
  logic sz_tail, sz_tq, sz_clr, sz_ph1, sz_done;

  tqcp_ram #(.WIDTH($bits(slot_word_t)), .DEPTH(ENTRIES)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (scan_idx_q[SW-1:0]),
    .rdata_o (slot_rd)
  );

  tqcp_ram #(.WIDTH($bits(rep_word_t)), .DEPTH(ENTRIES)) u_rep_ram (
    .clk_i   (clk_i),
    .we_i    (rep_we),
    .waddr_i (rcnt_q[SW-1:0]),
    .wdata_i (rep_wdata),
    .raddr_i (e_q[SW-1:0]),
    .rdata_o (rep_rd)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign scan_done   = pend_q && (pidx_q == LastIdx);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign rd_valid    = valid_q[pidx_q];
  assign rd_q2       = inq2_q[pidx_q];
  assign rd_expired  = (slot_rd.expiry != '0) && (slot_rd.expiry < now_q);
  assign fexpired    = (fexp_q != '0) && (fexp_q < now_q);
  assign q1ne        = |(valid_q & ~inq2_q);
  assign q2ne        = |(valid_q & inq2_q);
  assign tot         = (QbW+2)'(q1b_q) + (QbW+2)'(q2b_q) + (QbW+2)'(extra_q);
  assign q1x         = (QbW+1)'(q1b_q) + (QbW+1)'(extra_q);
  assign over_max    = (CfgW+1)'(tot) > (CfgW+1)'(max_q);
  assign cond1       = over_max && ((CfgW+1)'(q1x) > (CfgW+1)'(min_q));
  assign q1_over_min = (CfgW+1)'(q1b_q) > (CfgW+1)'(min_q);
  assign free_any    = ~&valid_q;
  assign alloc_tq    = !(q1ne && (q1_over_min || !q2ne)) && q2ne;
  assign bytes_over  = CfgW'(bytes_q) > max_q;
  assign exp_sum     = (SecW+1)'(now_q) + (SecW+1)'(life_q);
  assign exp_new     = (life_q == '0) ? '0 : (exp_sum[SecW] ? '1 : exp_sum[SecW-1:0]);
  assign now_inc     = (&now_q) ? now_q : now_q + 1'b1;

  always_comb begin
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  always_comb begin
    sz_tail = 1'b0;
    sz_tq   = 1'b0;
    sz_clr  = 1'b0;
    sz_ph1  = 1'b0;
    sz_done = 1'b0;
    if (!ph_q) begin
      if (cond1) begin
        if (q1ne) sz_tail = 1'b1;
        else if (extra_q != '0) sz_clr = 1'b1;
        else sz_ph1 = 1'b1;
      end else begin
        sz_ph1 = 1'b1;
      end
    end else begin
      if (over_max) begin
        if (q2ne) begin
          sz_tail = 1'b1;
          sz_tq   = 1'b1;
        end else if (q1ne) begin
          sz_tail = 1'b1;
        end else if (extra_q != '0) begin
          sz_clr = 1'b1;
        end else begin
          sz_done = 1'b1;
        end
      end else begin
        sz_done = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) state_d = (cmd_e'(command_i) == CmdTick) ? StExp : StFind;
      end
      StFind: begin
        if (scan_done) state_d = StAct;
      end
      StAct: begin
        if (cmd_q == CmdPut) state_d = bytes_over ? StSize : StAlloc;
        else state_d = StERd;
      end
      StAlloc:  state_d = free_any ? StSize : StTail;
      StTail: begin
        if (scan_done) state_d = StTailEv;
      end
      StTailEv: state_d = talloc_q ? StAlloc : StSize;
      StExp: begin
        if (scan_done) state_d = StSize;
      end
      StSize: begin
        if (sz_tail) state_d = StTail;
        else if (sz_done) state_d = StERd;
      end
      StERd:    state_d = (e_q == rcnt_q) ? StEFin : StELd;
      StELd: begin
        if (out_free) state_d = StERd;
      end
      StEFin: begin
        if (out_free) state_d = StIdle;
      end
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_d = cmd_q;  key_d = key_q;  bytes_d = bytes_q;  life_d = life_q;
    max_d = max_q;  min_d = min_q;
    valid_d = valid_q;  inq2_d = inq2_q;
    q1b_d = q1b_q;  q2b_d = q2b_q;
    hits_d = hits_q;  miss_d = miss_q;  now_d = now_q;  stamp_d = stamp_q;
    scan_idx_d = '0;  pend_d = 1'b0;  pidx_d = pidx_q;
    rcnt_d = rcnt_q;  e_d = e_q;
    found_d = found_q;  fslot_d = fslot_q;  fbytes_d = fbytes_q;  fexp_d = fexp_q;
    tq_d = tq_q;  talloc_d = talloc_q;  tfound_d = tfound_q;  tslot_d = tslot_q;
    tkey_d = tkey_q;  tbytes_d = tbytes_q;  tbest_d = tbest_q;
    extra_d = extra_q;  ph_d = ph_q;
    fin_sts_d = fin_sts_q;  fin_slot_d = fin_slot_q;
    out_valid_d = out_valid_q;  out_last_d = out_last_q;  out_sts_d = out_sts_q;
    out_key_d = out_key_q;  out_slot_d = out_slot_q;
    out_q1_d = out_q1_q;  out_q2_d = out_q2_q;
    out_hits_d = out_hits_q;  out_miss_d = out_miss_q;
    slot_we = 1'b0;  slot_waddr = fslot_q;
    slot_wdata = '{key: key_q, bytes: fbytes_q, expiry: fexp_q, stamp: stamp_q};
    rep_we = 1'b0;
    rep_wdata = '{key: tkey_q, slot: SlotW'(tslot_q)};

    if (cfg_valid_i) begin
      if (cfg_index_i == CfgMaxBytes) max_d = cfg_data_i;
      else if (cfg_index_i == CfgMinQ1Bytes) min_d = cfg_data_i;
    end

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    if (state_q == StFind || state_q == StTail || state_q == StExp) begin
      if (scan_idx_q != EntCnt) begin
        scan_idx_d = scan_idx_q + 1'b1;
        pend_d     = 1'b1;
        pidx_d     = scan_idx_q[SW-1:0];
      end else begin
        scan_idx_d = scan_idx_q;
      end
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_d      = cmd_e'(command_i);
          key_d      = key_hash_i;
          bytes_d    = entry_bytes_i;
          life_d     = lifetime_sec_i;
          rcnt_d     = '0;
          e_d        = '0;
          found_d    = 1'b0;
          talloc_d   = 1'b0;
          extra_d    = '0;
          ph_d       = 1'b0;
          fin_sts_d  = StsTickDone;
          fin_slot_d = '0;
          if (cmd_e'(command_i) == CmdTick) now_d = now_inc;
        end
      end
      StFind: begin
        if (pend_q && rd_valid && (slot_rd.key == key_q) && !found_q) begin
          found_d  = 1'b1;
          fslot_d  = pidx_q;
          fbytes_d = slot_rd.bytes;
          fexp_d   = slot_rd.expiry;
        end
      end
      StAct: begin
        case (cmd_q)
          CmdGet: begin
            if (found_q && !fexpired) begin
              hits_d = hits_q + 1'b1;
              if (!inq2_q[fslot_q]) begin
                q1b_d = q1b_q - QbW'(fbytes_q);
                q2b_d = q2b_q + QbW'(fbytes_q);
              end
              inq2_d[fslot_q] = 1'b1;
              slot_we    = 1'b1;
              stamp_d    = stamp_q + 1'b1;
              fin_sts_d  = StsHit;
              fin_slot_d = fslot_q;
            end else begin
              miss_d     = miss_q + 1'b1;
              fin_sts_d  = StsMiss;
            end
          end
          CmdRemove: begin
            if (found_q) begin
              valid_d[fslot_q] = 1'b0;
              if (inq2_q[fslot_q]) q2b_d = q2b_q - QbW'(fbytes_q);
              else q1b_d = q1b_q - QbW'(fbytes_q);
              fin_sts_d  = StsOk;
              fin_slot_d = fslot_q;
            end else begin
              fin_sts_d  = StsNotFound;
            end
          end
          CmdPut: begin
            if (found_q) begin
              valid_d[fslot_q] = 1'b0;
              if (inq2_q[fslot_q]) q2b_d = q2b_q - QbW'(fbytes_q);
              else q1b_d = q1b_q - QbW'(fbytes_q);
            end
            fin_sts_d = StsOk;
            if (bytes_over) extra_d = bytes_q;
          end
          default: begin
          end
        endcase
      end
      StAlloc: begin
        if (free_any) begin
          valid_d[free_slot] = 1'b1;
          inq2_d[free_slot]  = 1'b0;
          q1b_d      = q1b_q + QbW'(bytes_q);
          slot_we    = 1'b1;
          slot_waddr = free_slot;
          slot_wdata = '{key: key_q, bytes: bytes_q, expiry: exp_new, stamp: stamp_q};
          stamp_d    = stamp_q + 1'b1;
          fin_slot_d = free_slot;
        end else begin
          tq_d     = alloc_tq;
          talloc_d = 1'b1;
          tfound_d = 1'b0;
        end
      end
      StTail: begin
        if (pend_q && rd_valid && (rd_q2 == tq_q) &&
            (!tfound_q || (slot_rd.stamp < tbest_q))) begin
          tfound_d = 1'b1;
          tslot_d  = pidx_q;
          tkey_d   = slot_rd.key;
          tbytes_d = slot_rd.bytes;
          tbest_d  = slot_rd.stamp;
        end
      end
      StTailEv: begin
        valid_d[tslot_q] = 1'b0;
        if (inq2_q[tslot_q]) q2b_d = q2b_q - QbW'(tbytes_q);
        else q1b_d = q1b_q - QbW'(tbytes_q);
        rep_we   = 1'b1;
        rcnt_d   = rcnt_q + 1'b1;
        talloc_d = 1'b0;
      end
      StExp: begin
        if (pend_q && rd_valid && rd_expired) begin
          valid_d[pidx_q] = 1'b0;
          if (rd_q2) q2b_d = q2b_q - QbW'(slot_rd.bytes);
          else q1b_d = q1b_q - QbW'(slot_rd.bytes);
          rep_we    = 1'b1;
          rep_wdata = '{key: slot_rd.key, slot: SlotW'(pidx_q)};
          rcnt_d    = rcnt_q + 1'b1;
        end
      end
      StSize: begin
        if (sz_tail) begin
          tq_d     = sz_tq;
          talloc_d = 1'b0;
          tfound_d = 1'b0;
        end
        if (sz_clr) extra_d = '0;
        if (sz_ph1) ph_d = 1'b1;
      end
      StELd: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b0;
          out_sts_d   = StsEvicted;
          out_key_d   = rep_rd.key;
          out_slot_d  = rep_rd.slot;
          out_q1_d    = q1b_q;
          out_q2_d    = q2b_q;
          out_hits_d  = hits_q;
          out_miss_d  = miss_q;
          e_d         = e_q + 1'b1;
        end
      end
      StEFin: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_sts_d   = fin_sts_q;
          out_key_d   = (fin_sts_q == StsTickDone) ? '0 : key_q;
          out_slot_d  = SlotW'(fin_slot_q);
          out_q1_d    = q1b_q;
          out_q2_d    = q2b_q;
          out_hits_d  = hits_q;
          out_miss_d  = miss_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      max_q       <= MaxBytesRst;
      min_q       <= MinQ1Rst;
      valid_q     <= '0;
      inq2_q      <= '0;
      q1b_q       <= '0;
      q2b_q       <= '0;
      hits_q      <= '0;
      miss_q      <= '0;
      now_q       <= '0;
      stamp_q     <= '0;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      rcnt_q      <= '0;
      e_q         <= '0;
      found_q     <= 1'b0;
      talloc_q    <= 1'b0;
      tfound_q    <= 1'b0;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      max_q       <= max_d;
      min_q       <= min_d;
      valid_q     <= valid_d;
      inq2_q      <= inq2_d;
      q1b_q       <= q1b_d;
      q2b_q       <= q2b_d;
      hits_q      <= hits_d;
      miss_q      <= miss_d;
      now_q       <= now_d;
      stamp_q     <= stamp_d;
      scan_idx_q  <= scan_idx_d;
      pend_q      <= pend_d;
      rcnt_q      <= rcnt_d;
      e_q         <= e_d;
      found_q     <= found_d;
      talloc_q    <= talloc_d;
      tfound_q    <= tfound_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    bytes_q    <= bytes_d;
    life_q     <= life_d;
    pidx_q     <= pidx_d;
    fslot_q    <= fslot_d;
    fbytes_q   <= fbytes_d;
    fexp_q     <= fexp_d;
    tq_q       <= tq_d;
    tslot_q    <= tslot_d;
    tkey_q     <= tkey_d;
    tbytes_q   <= tbytes_d;
    tbest_q    <= tbest_d;
    extra_q    <= extra_d;
    fin_sts_q  <= fin_sts_d;
    fin_slot_q <= fin_slot_d;
    out_last_q <= out_last_d;
    out_sts_q  <= out_sts_d;
    out_key_q  <= out_key_d;
    out_slot_q <= out_slot_d;
    out_q1_q   <= out_q1_d;
    out_q2_q   <= out_q2_d;
    out_hits_q <= out_hits_d;
    out_miss_q <= out_miss_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_sts_q;
  assign out_key_o   = out_key_q;
  assign out_slot_o  = out_slot_q;
  assign q1_total_o  = out_q1_q;
  assign q2_total_o  = out_q2_q;
  assign hits_o      = out_hits_q;
  assign misses_o    = out_miss_q;
  assign last_o      = out_last_q;

endmodule
